// File: src/rgc_pkg.sv
// Shared types and constants for the RGB gradient color block.
// No dependencies; imported by the config register file, the channel pipeline and the top level.
`timescale 1ns / 1ps

package rgc_pkg;

	localparam int unsigned ColorW = 8;
	localparam int unsigned NumChan = 3;
	localparam int unsigned IndexW = 3;

	// config register indexes
	typedef enum logic [IndexW-1:0] {
		REG_START_RED   = 3'd0,
		REG_START_GREEN = 3'd1,
		REG_START_BLUE  = 3'd2,
		REG_END_RED     = 3'd3,
		REG_END_GREEN   = 3'd4,
		REG_END_BLUE    = 3'd5,
		REG_STEP_COUNT  = 3'd6
	} reg_index_t;

	localparam logic [ColorW-1:0] StepCountReset = 8'd1;

	typedef struct packed {
		logic [NumChan-1:0][ColorW-1:0] start_col;
		logic [NumChan-1:0][ColorW-1:0] end_col;
		logic [ColorW-1:0]              step_count;
	} cfg_t;

endpackage

// File: src/rgc_cfg.sv
// Configuration register file: start color, end color and step count.
// Depends on rgc_pkg.
`timescale 1ns / 1ps

module rgc_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [rgc_pkg::IndexW-1:0] wr_index,
	input  logic [rgc_pkg::ColorW-1:0] wr_data,
	output rgc_pkg::cfg_t              cfg
);
	import rgc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_col  <= '0;
			cfg_q.end_col    <= '0;
			cfg_q.step_count <= StepCountReset;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_START_RED:   cfg_q.start_col[0] <= wr_data;
				REG_START_GREEN: cfg_q.start_col[1] <= wr_data;
				REG_START_BLUE:  cfg_q.start_col[2] <= wr_data;
				REG_END_RED:     cfg_q.end_col[0] <= wr_data;
				REG_END_GREEN:   cfg_q.end_col[1] <= wr_data;
				REG_END_BLUE:    cfg_q.end_col[2] <= wr_data;
				REG_STEP_COUNT: begin
					// drop a zero step count
					if (wr_data != '0) cfg_q.step_count <= wr_data;
				end
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: src/rgc_channel.sv
// One color channel: multiply, four restoring divide stages of two bits, round and clamp.
// Depends on rgc_pkg.
`timescale 1ns / 1ps

module rgc_channel (
	input  logic                       clk,
	input  logic [rgc_pkg::ColorW-1:0] k_s1,
	input  logic [rgc_pkg::ColorW-1:0] start_col,
	input  logic [rgc_pkg::ColorW-1:0] end_col,
	input  logic [rgc_pkg::ColorW:0]   steps_p1,
	input  logic                       bad_s6,
	output logic [rgc_pkg::ColorW-1:0] result
);
	import rgc_pkg::*;

	localparam int unsigned RemW = 18;
	localparam int unsigned DenW = ColorW + 2;
	localparam int unsigned ProdW = 2 * ColorW;

	// one restoring step: quotient bit in the top bit, remainder below
	function automatic logic [RemW:0] div_step(input logic [RemW-1:0] rem,
		input logic [DenW-1:0] den, input logic [2:0] pos);
		logic [RemW-1:0] sub;
		sub = {{(RemW-DenW){1'b0}}, den} << pos;
		if (rem >= sub) return {1'b1, rem - sub};
		else return {1'b0, rem};
	endfunction

	logic              up;
	logic [ColorW-1:0] span;

	assign up   = start_col <= end_col;
	assign span = up ? end_col - start_col : start_col - end_col;

	logic [ProdW-1:0]  prod_s2;
	logic              up_s2, up_s3, up_s4, up_s5, up_s6;
	logic [ColorW-1:0] s_s2, s_s3, s_s4, s_s5, s_s6;
	logic [ColorW-1:0] e_s2, e_s3, e_s4, e_s5, e_s6;
	logic [DenW-1:0]   den_s2, den_s3, den_s4, den_s5;
	logic [RemW-1:0]   rem_s3, rem_s4, rem_s5;
	logic [ColorW-1:0] q_s3, q_s4, q_s5, q_s6;
	logic [ColorW-1:0] result_s7;

	logic [RemW-1:0] num;
	logic [RemW:0]   a3, b3, a4, b4, a5, b5, a6, b6;

	// 2kd + M, less one on a falling channel to turn round-half-up into round-half-down
	assign num = {1'b0, prod_s2, 1'b0} + {{(RemW-ColorW-1){1'b0}}, den_s2[DenW-1:1]}
		- {{(RemW-1){1'b0}}, ~up_s2};

	assign a3 = div_step(num, den_s2, 3'd7);
	assign b3 = div_step(a3[RemW-1:0], den_s2, 3'd6);
	assign a4 = div_step(rem_s3, den_s3, 3'd5);
	assign b4 = div_step(a4[RemW-1:0], den_s3, 3'd4);
	assign a5 = div_step(rem_s4, den_s4, 3'd3);
	assign b5 = div_step(a5[RemW-1:0], den_s4, 3'd2);
	assign a6 = div_step(rem_s5, den_s5, 3'd1);
	assign b6 = div_step(a6[RemW-1:0], den_s5, 3'd0);

	logic [ColorW:0]   sum;
	logic [ColorW:0]   diff;
	logic [ColorW-1:0] final_val;

	assign sum  = {1'b0, s_s6} + {1'b0, q_s6};
	assign diff = {1'b0, s_s6} - {1'b0, q_s6};

	always_comb begin
		if (bad_s6) final_val = '0;
		else if (up_s6) final_val = (sum > {1'b0, e_s6}) ? e_s6 : sum[ColorW-1:0];
		else if (diff[ColorW] || diff[ColorW-1:0] < e_s6) final_val = e_s6;
		else final_val = diff[ColorW-1:0];
	end

	always_ff @(posedge clk) begin
		prod_s2 <= k_s1 * span;
		up_s2   <= up;
		s_s2    <= start_col;
		e_s2    <= end_col;
		den_s2  <= {steps_p1, 1'b0};

		rem_s3 <= b3[RemW-1:0];
		q_s3   <= {6'd0, a3[RemW], b3[RemW]};
		up_s3  <= up_s2;
		s_s3   <= s_s2;
		e_s3   <= e_s2;
		den_s3 <= den_s2;

		rem_s4 <= b4[RemW-1:0];
		q_s4   <= {q_s3[5:0], a4[RemW], b4[RemW]};
		up_s4  <= up_s3;
		s_s4   <= s_s3;
		e_s4   <= e_s3;
		den_s4 <= den_s3;

		rem_s5 <= b5[RemW-1:0];
		q_s5   <= {q_s4[5:0], a5[RemW], b5[RemW]};
		up_s5  <= up_s4;
		s_s5   <= s_s4;
		e_s5   <= e_s4;
		den_s5 <= den_s4;

		q_s6  <= {q_s5[5:0], a6[RemW], b6[RemW]};
		up_s6 <= up_s5;
		s_s6  <= s_s5;
		e_s6  <= e_s5;

		result_s7 <= final_val;
	end

	assign result = result_s7;

endmodule

// File: src/rgb_gradient_step_colour.sv
// done rises with the color result, registered through k_s1, the k*d product, the
// divide stages and the final register. Throughput: one word per cycle; busy stays low.
// The depth is set by the divide by 2*(step_count+1), two quotient bits per stage over
// four stages, after the k*d multiply. The receiver cannot stall, so nothing holds the pipe.
// Reset clears config to its reset values and empties the valid pipeline.
`timescale 1ns / 1ps

module rgb_gradient_step_colour (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [rgc_pkg::ColorW-1:0] step_index,
	input  logic                       wr_en,
	input  logic [rgc_pkg::IndexW-1:0] wr_index,
	input  logic [rgc_pkg::ColorW-1:0] wr_data,
	output logic                       done,
	output logic [rgc_pkg::ColorW-1:0] out_red,
	output logic [rgc_pkg::ColorW-1:0] out_green,
	output logic [rgc_pkg::ColorW-1:0] out_blue
);
	import rgc_pkg::*;

	localparam int unsigned Depth = 7;

	cfg_t cfg;

	rgc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data),
		.cfg     (cfg)
	);

	assign busy = 1'b0;

	logic              accept;
	logic              bad;
	logic [ColorW-1:0] k_s1;
	logic [Depth-1:0]  valid_q;
	logic [5:0]        bad_q;

	assign accept = start && !busy;
	assign bad    = (step_index == '0) || (step_index > cfg.step_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= '0;
		else valid_q <= {valid_q[Depth-2:0], accept};
	end

	always_ff @(posedge clk) begin
		k_s1  <= step_index;
		bad_q <= {bad_q[4:0], bad};
	end

	logic [NumChan-1:0][ColorW-1:0] result;
	logic [ColorW:0]                steps_p1;

	assign steps_p1 = {1'b0, cfg.step_count} + 9'd1;

	for (genvar c = 0; c < NumChan; c++) begin : g_chan
		rgc_channel u_chan (
			.clk      (clk),
			.k_s1     (k_s1),
			.start_col(cfg.start_col[c]),
			.end_col  (cfg.end_col[c]),
			.steps_p1 (steps_p1),
			.bad_s6   (bad_q[5]),
			.result   (result[c])
		);
	end

	assign done      = valid_q[Depth-1];
	assign out_red   = result[0];
	assign out_green = result[1];
	assign out_blue  = result[2];

endmodule
